// ----- design/hct_pkg.sv -----
`default_nettype none
package hct_pkg;

    localparam int POS_W = 24;
    localparam int CEN_W = 24;
    localparam int D_W = ((POS_W > CEN_W) ? POS_W : CEN_W) + 1;
    localparam int SQ_W = 2 * D_W;
    localparam int NUM_W = POS_W + 32;
    localparam int REM_W = SQ_W + 32;
    localparam int N_SQRT = D_W;
    localparam int N_DIV = 32;
    localparam int CORDIC_STAGES = 18;
    localparam int N_CORDIC = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int N_CELL_A = (N_SQRT > N_DIV) ? N_SQRT : N_DIV;
    localparam int N_CELL = (N_CELL_A > N_CORDIC) ? N_CELL_A : N_CORDIC;
    localparam int IDX_W = $clog2(N_CELL);
    localparam int CR_W = 64;
    localparam int ANG_W = 34;
    localparam int NORM_MSB = 59;
    localparam int LZ_W = $clog2(NORM_MSB + 1);
    localparam int S_DW = ((32 + 3 * POS_W) + 7) / 8 * 8;
    localparam int M_DW = 104;

    typedef struct packed {
        logic [15:0]                hit_id;
        logic [15:0]                sensor_id;
        logic                       u_side;
        logic [1:0]                 sel;
        logic signed [POS_W-1:0]    raw_a;
        logic signed [POS_W-1:0]    raw_b;
        logic                       zero_r;
        logic                       phi_zero;
        logic [SQ_W-1:0]            r2;
        logic [SQ_W-1:0]            sq_n;
        logic [SQ_W:0]              sq_res;
        logic                       neg_x;
        logic                       neg_y;
        logic [NUM_W-1:0]           rem_x;
        logic [NUM_W-1:0]           rem_y;
        logic [31:0]                q_x;
        logic [31:0]                q_y;
        logic signed [CR_W-1:0]     cx;
        logic signed [CR_W-1:0]     cy;
        logic signed [ANG_W-1:0]    ang;
    } cell_t;

    // atan(2^-i) in units of pi/2^31
    function automatic logic [31:0] atan_lut(input logic [IDX_W-1:0] i);
        logic [31:0] v;
        case (i)
            0: v = 32'd536870912;
            1: v = 32'd316933406;
            2: v = 32'd167458907;
            3: v = 32'd85004756;
            4: v = 32'd42667331;
            5: v = 32'd21354465;
            6: v = 32'd10679838;
            7: v = 32'd5340245;
            8: v = 32'd2670163;
            9: v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- design/hct_cell.sv -----
`default_nettype none
module hct_cell (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire logic [hct_pkg::IDX_W-1:0]  idx,
    input  wire hct_pkg::cell_t             d_in,
    output hct_pkg::cell_t                  d_out
);
    import hct_pkg::*;

    cell_t d_reg;
    cell_t d_next;

    always_comb begin
        logic [SQ_W:0]          sbit;
        logic [SQ_W:0]          trial;
        logic [REM_W-1:0]       dk;
        logic [REM_W-1:0]       rx;
        logic [REM_W-1:0]       ry;
        logic signed [CR_W-1:0] xs;
        logic signed [CR_W-1:0] ys;
        logic signed [ANG_W-1:0] at;
        int                     sh;
        d_next = d_in;
        sh = 0;
        sbit = '0;
        trial = '0;
        dk = '0;
        rx = '0;
        ry = '0;
        xs = '0;
        ys = '0;
        at = '0;
        // one root bit
        if (int'(idx) < N_SQRT) begin
            sh = 2 * (N_SQRT - 1 - int'(idx));
            sbit = (SQ_W + 1)'(1) << sh;
            trial = d_in.sq_res + sbit;
            if ({1'b0, d_in.sq_n} >= trial) begin
                d_next.sq_n = SQ_W'({1'b0, d_in.sq_n} - trial);
                d_next.sq_res = (d_in.sq_res >> 1) + sbit;
            end else begin
                d_next.sq_res = d_in.sq_res >> 1;
            end
        end
        // one quotient bit for each coordinate, MSB first
        if (int'(idx) < N_DIV) begin
            sh = N_DIV - 1 - int'(idx);
            dk = REM_W'(d_in.r2) << sh;
            rx = REM_W'(d_in.rem_x);
            ry = REM_W'(d_in.rem_y);
            if (rx >= dk) begin
                d_next.rem_x = NUM_W'(rx - dk);
                d_next.q_x = {d_in.q_x[30:0], 1'b1};
            end else begin
                d_next.q_x = {d_in.q_x[30:0], 1'b0};
            end
            if (ry >= dk) begin
                d_next.rem_y = NUM_W'(ry - dk);
                d_next.q_y = {d_in.q_y[30:0], 1'b1};
            end else begin
                d_next.q_y = {d_in.q_y[30:0], 1'b0};
            end
        end
        // one vectoring rotation
        if (int'(idx) < N_CORDIC) begin
            xs = d_in.cx >>> idx;
            ys = d_in.cy >>> idx;
            at = ANG_W'(atan_lut(idx));
            if (d_in.cy > 0) begin
                d_next.cx = d_in.cx + ys;
                d_next.cy = d_in.cy - xs;
                d_next.ang = d_in.ang + at;
            end else begin
                d_next.cx = d_in.cx - ys;
                d_next.cy = d_in.cy + xs;
                d_next.ang = d_in.ang - at;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule
`default_nettype wire

// ----- design/hough_conformal_hit_transform_core.sv -----
// Channel  | Ports      | tdata fields (low bit up)                          | tuser
// ---------+------------+----------------------------------------------------+----------
// input    | s_t*       | hit_id, sensor_id, pos_x, pos_y, pos_z             | is_u_side
// result   | m_t*       | out_hit_id, out_sensor_id, hough_a, hough_b,       | out_u_side
//          |            | zero_radius, zero pad                              |
// config   | APB        | conformal_on, phase2_mode, uside_mode, center_x/y  | -
//
// One hit enters per cycle unless the pipeline holds; its result passes three front
// stages, a chain of 32 cells and the output register. The chain length is set by the
// 32 quotient bits of the conformal divide, one bit per cell.
// Reset clears the valid bits and the configuration registers; data registers
// keep their contents. The pipeline holds as a whole while a result waits in the
// output register and m_tready is low.
`default_nettype none
module hough_conformal_hit_transform_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output      logic                       s_tready,
    // hit_id[15:0], sensor_id[31:16], pos_x, pos_y, pos_z
    input  wire logic [hct_pkg::S_DW-1:0]   s_tdata,
    // is_u_side[0]
    input  wire logic [0:0]                 s_tuser,
    output      logic                       m_tvalid,
    input  wire logic                       m_tready,
    // out_hit_id[15:0], out_sensor_id[31:16], hough_a[63:32], hough_b[95:64],
    // zero_radius[96]
    output      logic [hct_pkg::M_DW-1:0]   m_tdata,
    // out_u_side[0]
    output      logic [0:0]                 m_tuser,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [4:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output      logic [31:0]                prdata,
    output      logic                       pready
);
    import hct_pkg::*;

    localparam logic [2:0] REG_CONF_ON = 3'd0;
    localparam logic [2:0] REG_PHASE2  = 3'd1;
    localparam logic [2:0] REG_USIDE   = 3'd2;
    localparam logic [2:0] REG_CX      = 3'd3;
    localparam logic [2:0] REG_CY      = 3'd4;

    localparam logic [1:0] UM_CONF = 2'd0;
    localparam logic [1:0] UM_RPHI = 2'd1;

    localparam logic [1:0] SEL_RAW  = 2'd0;
    localparam logic [1:0] SEL_VR   = 2'd1;
    localparam logic [1:0] SEL_CONF = 2'd2;
    localparam logic [1:0] SEL_RPHI = 2'd3;

    localparam logic signed [ANG_W-1:0] ANG_PI = {{(ANG_W - 32){1'b0}}, 32'h8000_0000};
    localparam logic signed [31:0] I32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;

    // ---------------- configuration registers ----------------
    logic                    conf_on_reg;
    logic                    phase2_reg;
    logic [1:0]              uside_reg;
    logic signed [CEN_W-1:0] cen_x_reg;
    logic signed [CEN_W-1:0] cen_y_reg;
    logic                    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conf_on_reg <= 1'b0;
            phase2_reg <= 1'b0;
            uside_reg <= '0;
            cen_x_reg <= '0;
            cen_y_reg <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_CONF_ON: conf_on_reg <= pwdata[0];
                REG_PHASE2:  phase2_reg <= pwdata[0];
                REG_USIDE:   uside_reg <= pwdata[1:0];
                REG_CX:      cen_x_reg <= pwdata[CEN_W-1:0];
                REG_CY:      cen_y_reg <= pwdata[CEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_CONF_ON: prdata = {31'd0, conf_on_reg};
            REG_PHASE2:  prdata = {31'd0, phase2_reg};
            REG_USIDE:   prdata = {30'd0, uside_reg};
            REG_CX:      prdata = 32'({1'b0, cen_x_reg});
            REG_CY:      prdata = 32'({1'b0, cen_y_reg});
            default:     prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    // Advance the whole pipeline unless the output register holds a result
    // that is not taken in this cycle.
    logic en;
    logic v1_reg, v2_reg, v3_reg;
    logic [N_CELL-1:0] cv_reg;
    logic m_valid_reg;

    assign en = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            cv_reg <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            cv_reg <= {cv_reg[N_CELL-2:0], v3_reg};
            m_valid_reg <= cv_reg[N_CELL-1];
        end
    end

    // ---------------- stage 1: decode, offsets from center ----------------
    logic signed [POS_W-1:0] in_x, in_y, in_z;
    logic                    in_u;
    logic [1:0]              sel_next;
    logic signed [POS_W-1:0] ra_next, rb_next;
    logic signed [D_W-1:0]   dx_next, dy_next;

    assign in_x = s_tdata[32 +: POS_W];
    assign in_y = s_tdata[32 + POS_W +: POS_W];
    assign in_z = s_tdata[32 + 2 * POS_W +: POS_W];
    assign in_u = s_tuser[0];

    always_comb begin
        ra_next = in_x;
        rb_next = in_y;
        if (!in_u) begin
            sel_next = phase2_reg ? SEL_RAW : SEL_VR;
            rb_next = in_z;
        end else if (conf_on_reg && (uside_reg == UM_CONF || uside_reg == UM_RPHI)) begin
            sel_next = (uside_reg == UM_CONF) ? SEL_CONF : SEL_RPHI;
        end else begin
            // raw x, y, also for the undefined u-side mode
            sel_next = SEL_RAW;
        end
        if (in_u && phase2_reg) begin
            dx_next = D_W'(in_x) - D_W'(cen_x_reg);
            dy_next = D_W'(in_y) - D_W'(cen_y_reg);
        end else begin
            dx_next = D_W'(in_x);
            dy_next = D_W'(in_y);
        end
    end

    logic [15:0]             s1_hit_reg, s1_sen_reg;
    logic                    s1_u_reg;
    logic [1:0]              s1_sel_reg;
    logic signed [POS_W-1:0] s1_ra_reg, s1_rb_reg, s1_x_reg, s1_y_reg;
    logic signed [D_W-1:0]   s1_dx_reg, s1_dy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_hit_reg <= s_tdata[15:0];
            s1_sen_reg <= s_tdata[31:16];
            s1_u_reg <= in_u;
            s1_sel_reg <= sel_next;
            s1_ra_reg <= ra_next;
            s1_rb_reg <= rb_next;
            s1_x_reg <= in_x;
            s1_y_reg <= in_y;
            s1_dx_reg <= dx_next;
            s1_dy_reg <= dy_next;
        end
    end

    // ---------------- stage 2: squares, CORDIC and divide setup ----------------
    logic signed [SQ_W-1:0]    px, py;
    logic signed [POS_W:0]     cx0, cy0;
    logic signed [ANG_W-1:0]   ang0;
    logic [POS_W:0]            mxm, mym, mm;
    logic [LZ_W-1:0]           nsh;
    logic [POS_W-1:0]          ax, ay;

    assign px = s1_dx_reg * s1_dx_reg;
    assign py = s1_dy_reg * s1_dy_reg;

    always_comb begin
        int p;
        p = 0;
        // fold the left half plane onto the right one
        if (s1_x_reg < 0) begin
            cx0 = -(POS_W + 1)'(s1_x_reg);
            cy0 = -(POS_W + 1)'(s1_y_reg);
            ang0 = (s1_y_reg >= 0) ? ANG_PI : -ANG_PI;
        end else begin
            cx0 = (POS_W + 1)'(s1_x_reg);
            cy0 = (POS_W + 1)'(s1_y_reg);
            ang0 = '0;
        end
        mxm = (cx0 < 0) ? $unsigned(-cx0) : $unsigned(cx0);
        mym = (cy0 < 0) ? $unsigned(-cy0) : $unsigned(cy0);
        mm = (mxm > mym) ? mxm : mym;
        for (int j = 0; j <= POS_W; j++) begin
            if (mm[j]) begin
                p = j;
            end
        end
        nsh = LZ_W'(NORM_MSB - p);
        ax = (s1_x_reg < 0) ? POS_W'(-s1_x_reg) : POS_W'(s1_x_reg);
        ay = (s1_y_reg < 0) ? POS_W'(-s1_y_reg) : POS_W'(s1_y_reg);
    end

    logic [15:0]             s2_hit_reg, s2_sen_reg;
    logic                    s2_u_reg;
    logic [1:0]              s2_sel_reg;
    logic signed [POS_W-1:0] s2_ra_reg, s2_rb_reg;
    logic [SQ_W-1:0]         s2_sqx_reg, s2_sqy_reg;
    logic signed [POS_W:0]   s2_cx_reg, s2_cy_reg;
    logic signed [ANG_W-1:0] s2_ang_reg;
    logic                    s2_pz_reg;
    logic [LZ_W-1:0]         s2_sh_reg;
    logic [POS_W-1:0]        s2_ax_reg, s2_ay_reg;
    logic                    s2_nx_reg, s2_ny_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_hit_reg <= s1_hit_reg;
            s2_sen_reg <= s1_sen_reg;
            s2_u_reg <= s1_u_reg;
            s2_sel_reg <= s1_sel_reg;
            s2_ra_reg <= s1_ra_reg;
            s2_rb_reg <= s1_rb_reg;
            s2_sqx_reg <= $unsigned(px);
            s2_sqy_reg <= $unsigned(py);
            s2_cx_reg <= cx0;
            s2_cy_reg <= cy0;
            s2_ang_reg <= ang0;
            s2_pz_reg <= (s1_x_reg == 0) && (s1_y_reg == 0);
            s2_sh_reg <= nsh;
            s2_ax_reg <= ax;
            s2_ay_reg <= ay;
            s2_nx_reg <= s1_x_reg < 0;
            s2_ny_reg <= s1_y_reg < 0;
        end
    end

    // ---------------- stage 3: r^2, normalize CORDIC inputs ----------------
    cell_t c0_next;
    cell_t c0_reg;
    logic [SQ_W-1:0] r2;

    assign r2 = s2_sqx_reg + s2_sqy_reg;

    always_comb begin
        c0_next.hit_id = s2_hit_reg;
        c0_next.sensor_id = s2_sen_reg;
        c0_next.u_side = s2_u_reg;
        c0_next.sel = s2_sel_reg;
        c0_next.raw_a = s2_ra_reg;
        c0_next.raw_b = s2_rb_reg;
        c0_next.zero_r = (r2 == '0);
        c0_next.phi_zero = s2_pz_reg;
        c0_next.r2 = r2;
        c0_next.sq_n = r2;
        c0_next.sq_res = '0;
        c0_next.neg_x = s2_nx_reg;
        c0_next.neg_y = s2_ny_reg;
        c0_next.rem_x = {s2_ax_reg, 32'd0};
        c0_next.rem_y = {s2_ay_reg, 32'd0};
        c0_next.q_x = '0;
        c0_next.q_y = '0;
        c0_next.cx = CR_W'(s2_cx_reg) <<< s2_sh_reg;
        c0_next.cy = CR_W'(s2_cy_reg) <<< s2_sh_reg;
        c0_next.ang = s2_ang_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c0_reg <= c0_next;
        end
    end

    // ---------------- chain of cells ----------------
    cell_t chain [N_CELL+1];
    assign chain[0] = c0_reg;

    for (genvar k = 0; k < N_CELL; k++) begin : g_cell
        hct_cell u_cell (
            .aclk  (aclk),
            .en    (en),
            .idx   (IDX_W'(k)),
            .d_in  (chain[k]),
            .d_out (chain[k+1])
        );
    end

    // ---------------- output stage ----------------
    cell_t                   cl;
    logic signed [31:0]      ha, hb, root_s, qxs, qys;
    logic                    zr;
    logic signed [ANG_W-1:0] phi;
    logic signed [ANG_W:0]   rsum;

    assign cl = chain[N_CELL];

    always_comb begin
        root_s = (cl.sq_res > (SQ_W + 1)'(I32_MAX)) ? I32_MAX : 32'(cl.sq_res);
        if (cl.neg_x) begin
            qxs = cl.q_x[31] ? I32_MIN : -$signed({1'b0, cl.q_x[30:0]});
        end else begin
            qxs = cl.q_x[31] ? I32_MAX : $signed({1'b0, cl.q_x[30:0]});
        end
        if (cl.neg_y) begin
            qys = cl.q_y[31] ? I32_MIN : -$signed({1'b0, cl.q_y[30:0]});
        end else begin
            qys = cl.q_y[31] ? I32_MAX : $signed({1'b0, cl.q_y[30:0]});
        end
        phi = cl.phi_zero ? '0 : cl.ang;
        // round to pi/2^15 half up, then drop pi/2
        rsum = (ANG_W + 1)'(phi) + (ANG_W + 1)'(ANG_PI) + (ANG_W + 1)'(32768);
        zr = 1'b0;
        case (cl.sel)
            SEL_RAW: begin
                ha = 32'(cl.raw_a);
                hb = 32'(cl.raw_b);
            end
            SEL_VR: begin
                ha = root_s;
                hb = 32'(cl.raw_b);
            end
            SEL_CONF: begin
                ha = qxs;
                hb = qys;
            end
            default: begin
                ha = (rsum < 0) ? I32_MAX : 32'(rsum >>> 16) - 32'sd49152;
                hb = root_s;
            end
        endcase
        if ((cl.sel == SEL_CONF || cl.sel == SEL_RPHI) && cl.zero_r) begin
            ha = '0;
            hb = '0;
            zr = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata <= {7'd0, zr, hb, ha, cl.sensor_id, cl.hit_id};
            m_tuser <= cl.u_side;
        end
    end

endmodule
`default_nettype wire

// ----- design/hct_checker.sv -----
`default_nettype none
module hct_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_tready,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [hct_pkg::M_DW-1:0]   m_tdata,
    input wire logic [0:0]                 m_tuser
);
    import hct_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // zero radius only on the u side, with both coordinates cleared
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[96] |-> (m_tdata[95:32] == '0) && m_tuser[0])
        else $error("zero radius flag with bad coordinates");

    // input side advances exactly when the output register frees up
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready does not follow output stall");

    // drop all results on reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind hough_conformal_hit_transform_core hct_checker u_hct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
